FILE: src/affine_matrix_inverse_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project
// ---------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_DEFINES_SVH
`define AFFINE_MATRIX_INVERSE_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define AMI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is held
`define AMI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ami_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ami_pkg
// Widths, tables and the queued item type of the affine matrix inverse.
// ---------------------------------------------------------------------------
package ami_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EW = 32;          // entry and result width
	localparam int AW = 2 * EW + 1;  // cofactor width
	localparam int PW = AW + EW;     // cofactor times entry
	localparam int DW = PW + 2;      // sum of three such products
	localparam int NENT = 12;
	localparam int NADJ = 9;
	localparam int NTERM = 12;
	localparam int NPROD = 2 * NADJ;
	localparam int QDEPTH = 4;
	localparam int QPW = $clog2(QDEPTH);
	localparam int DIV_LAT = 3 + EW;  // registers inside one divider lane
	localparam logic [1:0] ROW_LAST = 2'd2;

	// entry positions of the input item
	localparam logic [3:0] E_TX = 4'd3;
	localparam logic [3:0] E_TY = 4'd7;
	localparam logic [3:0] E_TZ = 4'd11;

	// cofactor k = ent[P0] * ent[P1] - ent[N0] * ent[N1]
	localparam logic [3:0] ADJ_P0 [NADJ] = '{4'd5, 4'd2, 4'd1, 4'd6, 4'd0, 4'd2, 4'd4, 4'd1, 4'd0};
	localparam logic [3:0] ADJ_P1 [NADJ] = '{4'd10, 4'd9, 4'd6, 4'd8, 4'd10, 4'd4, 4'd9, 4'd8, 4'd5};
	localparam logic [3:0] ADJ_N0 [NADJ] = '{4'd6, 4'd1, 4'd2, 4'd4, 4'd2, 4'd0, 4'd5, 4'd0, 4'd1};
	localparam logic [3:0] ADJ_N1 [NADJ] = '{4'd9, 4'd10, 4'd5, 4'd10, 4'd8, 4'd6, 4'd8, 4'd9, 4'd4};

	// wide products: three determinant terms, then three per translation row
	localparam logic [3:0] TERM_ADJ [NTERM] =
		'{4'd0, 4'd3, 4'd6, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};
	localparam logic [3:0] TERM_ENT [NTERM] =
		'{4'd0, 4'd1, 4'd2, E_TX, E_TY, E_TZ, E_TX, E_TY, E_TZ, E_TX, E_TY, E_TZ};

	typedef struct packed {
		logic [NADJ-1:0][AW-1:0] adj;
		logic [2:0][DW-1:0]      t;
		logic [DW-1:0]           absdet;
		logic                    det_neg;
		logic                    sing;
	} ami_item_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} ami_qctl_t;

endpackage

FILE: src/ami_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ami_front
// Cofactors, determinant, translation sums and singular test, seven stages.
// ---------------------------------------------------------------------------
module ami_front import ami_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic signed [EW-1:0] ent [NENT],
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	output logic                 push,
	output ami_item_t            item
);

	logic [15:0] thr_q;
	logic [6:0]  v_q;

	logic signed [EW-1:0]    e_s1 [NENT];
	logic signed [EW-1:0]    e_s2 [NENT];
	logic signed [EW-1:0]    e_s3 [NENT];
	logic signed [2*EW-1:0]  p_s2 [NPROD];
	logic signed [AW-1:0]    adj_s3 [NADJ];
	logic signed [AW-1:0]    adj_s4 [NADJ];
	logic signed [AW-1:0]    adj_s5 [NADJ];
	logic signed [AW-1:0]    adj_s6 [NADJ];
	logic signed [AW-1:0]    adj_s7 [NADJ];
	logic signed [2*EW+1:0]  plo_s4 [NTERM];
	logic signed [2*EW-1:0]  phi_s4 [NTERM];
	logic signed [PW-1:0]    prod_s5 [NTERM];
	logic signed [DW-1:0]    det_s6;
	logic signed [DW-1:0]    t_s6 [3];
	logic signed [DW-1:0]    t_s7 [3];
	logic [DW-1:0]           absdet_s7;
	logic                    neg_s7;
	logic [DW-1:0]           thr_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd1;
			v_q   <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			v_q <= {v_q[5:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= ent;
		e_s2 <= e_s1;
		e_s3 <= e_s2;
		for (int k = 0; k < NADJ; k++) begin
			p_s2[2*k]   <= e_s1[ADJ_P0[k]] * e_s1[ADJ_P1[k]];
			p_s2[2*k+1] <= e_s1[ADJ_N0[k]] * e_s1[ADJ_N1[k]];
			adj_s3[k]   <= AW'(p_s2[2*k]) - AW'(p_s2[2*k+1]);
		end
		// split each cofactor into a signed top half and an unsigned low part
		for (int m = 0; m < NTERM; m++) begin
			plo_s4[m]  <= $signed({1'b0, adj_s3[TERM_ADJ[m]][EW:0]}) * e_s3[TERM_ENT[m]];
			phi_s4[m]  <= $signed(adj_s3[TERM_ADJ[m]][AW-1:EW+1]) * e_s3[TERM_ENT[m]];
			prod_s5[m] <= (PW'(phi_s4[m]) <<< (EW + 1)) + PW'(plo_s4[m]);
		end
		adj_s4 <= adj_s3;
		adj_s5 <= adj_s4;
		adj_s6 <= adj_s5;
		adj_s7 <= adj_s6;
		det_s6 <= DW'(prod_s5[0]) + DW'(prod_s5[1]) + DW'(prod_s5[2]);
		for (int r = 0; r < 3; r++) begin
			t_s6[r] <= DW'(prod_s5[3+3*r]) + DW'(prod_s5[4+3*r]) + DW'(prod_s5[5+3*r]);
		end
		t_s7      <= t_s6;
		neg_s7    <= det_s6[DW-1];
		absdet_s7 <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
	end

	assign thr_sh = DW'(thr_q) << (2 * FRAC_BITS);

	always_comb begin
		for (int k = 0; k < NADJ; k++) begin
			item.adj[k] = adj_s7[k];
		end
		for (int r = 0; r < 3; r++) begin
			item.t[r] = t_s7[r];
		end
		item.absdet  = absdet_s7;
		item.det_neg = neg_s7;
		// zero determinant counts as singular even with a zero threshold
		item.sing    = (absdet_s7 == '0) || (absdet_s7 < thr_sh);
	end

	assign push = v_q[6];

endmodule

FILE: src/ami_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ami_queue
// Short item queue between front and back, with a credit count that also
// covers items still inside the front pipeline.
// ---------------------------------------------------------------------------
module ami_queue import ami_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic      push,
	input  ami_item_t wr_item,
	input  logic      pop,
	output ami_qctl_t ctl,
	output ami_item_t rd_item
);

	ami_item_t        mem_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     fill_q;
	logic [QPW:0]     credit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q   <= fill_q + (QPW+1)'(push) - (QPW+1)'(pop);
			credit_q <= credit_q + (QPW+1)'(accept) - (QPW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	assign rd_item   = mem_q[rd_ptr_q];
	assign ctl.valid = (fill_q != '0);
	assign ctl.ready = (credit_q != (QPW+1)'(QDEPTH));

endmodule

FILE: src/ami_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ami_div
// Pipelined rounding divider lane: |n| * 2^SHIFT / |det|, ties away from
// zero, one quotient bit per stage, overflow flagged for saturation.
// ---------------------------------------------------------------------------
module ami_div import ami_pkg::*; #(
	parameter int SHIFT = 2 * FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] val,
	input  logic                 flip,
	input  logic [DW-1:0]        absdet,
	input  logic                 det_neg,
	output logic [EW-1:0]        quo,
	output logic                 ovf,
	output logic                 neg
);

	localparam int NW  = DW + SHIFT + 2;
	localparam int DDW = DW + 1 + EW;
	localparam int CW  = (NW > DDW ? NW : DDW) + 1;

	logic [DW-1:0] mag_s1;
	logic [DW-1:0] ad_s1;
	logic          neg_s1;
	logic [CW-1:0] num_s2;
	logic [DW:0]   den_s2;
	logic          neg_s2;

	logic [CW-1:0] rem_p [EW+1];
	logic [DW:0]   den_p [EW+1];
	logic [EW-1:0] quo_p [EW+1];
	logic          neg_p [EW+1];
	logic          ovf_p [EW+1];

	always_ff @(posedge clk) begin
		mag_s1 <= val[DW-1] ? DW'(-val) : DW'(val);
		neg_s1 <= val[DW-1] ^ flip ^ det_neg;
		ad_s1  <= absdet;
		// 2|n| * 2^SHIFT + |d| over 2|d| rounds half away from zero
		num_s2 <= (CW'(mag_s1) << (SHIFT + 1)) + CW'(ad_s1);
		den_s2 <= {ad_s1, 1'b0};
		neg_s2 <= neg_s1;
		rem_p[0] <= num_s2;
		den_p[0] <= den_s2;
		quo_p[0] <= '0;
		neg_p[0] <= neg_s2;
		ovf_p[0] <= num_s2 >= (CW'(den_s2) << EW);
	end

	for (genvar k = 0; k < EW; k++) begin : g_step
		localparam int J = EW - 1 - k;
		logic [CW-1:0] sub;
		logic          take;
		assign sub  = CW'(den_p[k]) << J;
		assign take = rem_p[k] >= sub;
		always_ff @(posedge clk) begin
			rem_p[k+1] <= take ? rem_p[k] - sub : rem_p[k];
			quo_p[k+1] <= {quo_p[k][EW-2:0], take};
			den_p[k+1] <= den_p[k];
			neg_p[k+1] <= neg_p[k];
			ovf_p[k+1] <= ovf_p[k];
		end
	end

	assign quo = quo_p[EW];
	assign ovf = ovf_p[EW] | (rem_p[EW] == '0 & 1'b0);
	assign neg = neg_p[EW];

endmodule

FILE: src/ami_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ami_back
// Issues one row per cycle into four divider lanes, then saturates and
// substitutes identity rows for singular matrices.
// ---------------------------------------------------------------------------
module ami_back import ami_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ami_qctl_t            qctl,
	input  ami_item_t            item,
	output logic                 pop,
	output logic                 result_strobe,
	output logic [1:0]           row_index,
	output logic signed [EW-1:0] inv_col0,
	output logic signed [EW-1:0] inv_col1,
	output logic signed [EW-1:0] inv_col2,
	output logic signed [EW-1:0] inv_trans,
	output logic                 singular,
	output logic                 last_row
);

	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		logic       sing;
	} ami_ctl_t;

	ami_item_t cur_q;
	logic      issuing_q;
	logic [1:0] row_q;

	logic signed [DW-1:0] val_s0 [4];
	logic [DW-1:0]        absdet_s0;
	logic                 det_neg_s0;
	ami_ctl_t             ctl_p [DIV_LAT+1];

	logic [EW-1:0] quo [4];
	logic          ovf [4];
	logic          neg [4];
	logic [EW-1:0] sat [4];
	logic [EW-1:0] one;
	ami_ctl_t      ctl_o;

	logic                 strobe_q;
	logic [1:0]           row_q2;
	logic signed [EW-1:0] col_q [3];
	logic signed [EW-1:0] trans_q;
	logic                 sing_q;

	assign pop = qctl.valid && (!issuing_q || row_q == ROW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			row_q     <= '0;
			strobe_q  <= 1'b0;
			for (int s = 0; s <= DIV_LAT; s++) begin
				ctl_p[s] <= '0;
			end
		end else begin
			if (pop) begin
				issuing_q <= 1'b1;
				row_q     <= '0;
			end else if (issuing_q) begin
				if (row_q == ROW_LAST) begin
					issuing_q <= 1'b0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			ctl_p[0] <= '{valid: issuing_q, row: row_q, sing: cur_q.sing};
			for (int s = 1; s <= DIV_LAT; s++) begin
				ctl_p[s] <= ctl_p[s-1];
			end
			strobe_q <= ctl_o.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= item;
		end
		for (int k = 0; k < 3; k++) begin
			val_s0[k] <= DW'($signed(cur_q.adj[4'(row_q) * 4'd3 + 4'(k)]));
		end
		val_s0[3]  <= $signed(cur_q.t[row_q]);
		absdet_s0  <= cur_q.absdet;
		det_neg_s0 <= cur_q.det_neg;
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		ami_div #(
			.SHIFT(l == 3 ? FRAC_BITS : 2 * FRAC_BITS)
		) u_div (
			.clk     (clk),
			.val     (val_s0[l]),
			.flip    (l == 3),
			.absdet  (absdet_s0),
			.det_neg (det_neg_s0),
			.quo     (quo[l]),
			.ovf     (ovf[l]),
			.neg     (neg[l])
		);
		logic [EW-1:0] lim;
		logic [EW-1:0] mag;
		assign lim    = neg[l] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
		assign mag    = (ovf[l] || quo[l] > lim) ? lim : quo[l];
		assign sat[l] = neg[l] ? EW'(-mag) : mag;
	end

	assign ctl_o = ctl_p[DIV_LAT];
	assign one   = EW'(1) << FRAC_BITS;

	always_ff @(posedge clk) begin
		row_q2 <= ctl_o.row;
		sing_q <= ctl_o.sing;
		for (int k = 0; k < 3; k++) begin
			if (ctl_o.sing) begin
				col_q[k] <= (ctl_o.row == 2'(k)) ? one : '0;
			end else begin
				col_q[k] <= sat[k];
			end
		end
		trans_q <= ctl_o.sing ? '0 : sat[3];
	end

	assign result_strobe = strobe_q;
	assign row_index     = row_q2;
	assign inv_col0      = col_q[0];
	assign inv_col1      = col_q[1];
	assign inv_col2      = col_q[2];
	assign inv_trans     = trans_q;
	assign singular      = sing_q;
	assign last_row      = (row_q2 == ROW_LAST);

endmodule

FILE: src/affine_matrix_inverse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of a 3x4 affine matrix in signed fixed point, three rows out.
// ---------------------------------------------------------------------------
// channel   handshake            payload
// input     start / busy         m00..m23
// config    cfg_we               cfg_data (det_threshold)
// result    result_strobe        row_index, inv_col0..2, inv_trans, singular,
//                                last_row
//
// The back end takes the next item while it issues the last row of the one
// before, one row per cycle into four 35-stage divider lanes. The first row
// passes the front, the queue, the item and operand registers, the lanes and
// the output register. busy rises when four items are in the front or queue.
// Reset clears all control state at once; results cannot be held off.
// ---------------------------------------------------------------------------
module affine_matrix_inverse import ami_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [EW-1:0] m00,
	input  logic signed [EW-1:0] m01,
	input  logic signed [EW-1:0] m02,
	input  logic signed [EW-1:0] m03,
	input  logic signed [EW-1:0] m10,
	input  logic signed [EW-1:0] m11,
	input  logic signed [EW-1:0] m12,
	input  logic signed [EW-1:0] m13,
	input  logic signed [EW-1:0] m20,
	input  logic signed [EW-1:0] m21,
	input  logic signed [EW-1:0] m22,
	input  logic signed [EW-1:0] m23,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	output logic                 result_strobe,
	output logic [1:0]           row_index,
	output logic signed [EW-1:0] inv_col0,
	output logic signed [EW-1:0] inv_col1,
	output logic signed [EW-1:0] inv_col2,
	output logic signed [EW-1:0] inv_trans,
	output logic                 singular,
	output logic                 last_row
);

	logic signed [EW-1:0] ent [NENT];
	logic                 accept;
	logic                 push;
	logic                 pop;
	ami_item_t            wr_item;
	ami_item_t            rd_item;
	ami_qctl_t            qctl;

	assign ent    = '{m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23};
	assign busy   = !qctl.ready;
	assign accept = start && qctl.ready;

	ami_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ent      (ent),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (wr_item)
	);

	ami_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.ctl     (qctl),
		.rd_item (rd_item)
	);

	ami_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qctl          (qctl),
		.item          (rd_item),
		.pop           (pop),
		.result_strobe (result_strobe),
		.row_index     (row_index),
		.inv_col0      (inv_col0),
		.inv_col1      (inv_col1),
		.inv_col2      (inv_col2),
		.inv_trans     (inv_trans),
		.singular      (singular),
		.last_row      (last_row)
	);

endmodule

FILE: src/ami_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ami_checker
// Port-level checks on the row sequence and singular rows of the affine matrix inverse.
// ---------------------------------------------------------------------------
`include "affine_matrix_inverse_defines.svh"

module ami_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_strobe,
	input logic [1:0]  row_index,
	input logic [31:0] inv_trans,
	input logic        singular,
	input logic        last_row
);

	`AMI_ASSERT_NOW(a_last_row, result_strobe, last_row == (row_index == 2'd2), "last_row mismatch")
	`AMI_ASSERT_NEXT(a_row1, result_strobe && row_index == 2'd0, result_strobe && row_index == 2'd1, "row 1 must follow row 0")
	`AMI_ASSERT_NEXT(a_row2, result_strobe && row_index == 2'd1, result_strobe && row_index == 2'd2 && singular == $past(singular), "row 2 must follow row 1 of the same item")
	`AMI_ASSERT_NOW(a_sing_trans, result_strobe && singular, inv_trans == 32'd0, "singular row with translation")

endmodule

bind affine_matrix_inverse ami_checker u_ami_checker (.*);
